/* sv/ffrw_pkg.sv */
// Shared types and codes for the fair reader-writer lock manager.
package ffrw_pkg;

    localparam int FIELD_ID_W = 8;
    localparam int READER_W   = 9;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic MODE_SHARED = 1'b0;
    localparam logic MODE_EXCL   = 1'b1;

    localparam logic [1:0] STATUS_GRANT    = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_UNLOCKED = 2'd2;

    localparam logic [1:0] LOCK_FREE   = 2'd0;
    localparam logic [1:0] LOCK_SHARED = 2'd1;
    localparam logic [1:0] LOCK_EXCL   = 2'd2;

    localparam logic [READER_W-1:0] READER_MAX = 9'd511;

    typedef struct packed {
        logic                  kind;
        logic [FIELD_ID_W-1:0] requester_id;
        logic                  mode;
    } in_word_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [FIELD_ID_W-1:0] granted_id;
        logic                  granted_mode;
        logic                  last;
    } out_word_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } push_t;

endpackage

/* sv/ffrw_ram.sv */
// Generic single-clock RAM, one write port, one registered read port.
module ffrw_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/ffrw_out_reg.sv */
// Result output register between the sequencer and the result channel.
module ffrw_out_reg
    import ffrw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  push_t     push,
    output logic      out_free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      valid_reg, valid_next;
    out_word_t data_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (push.valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            data_reg <= push.word;
        end
    end

endmodule

/* sv/ffrw_seq.sv */
// Lock sequencer: queue pointers, lock state and grant run over the wait RAM.
module ffrw_seq
    import ffrw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int SW = (ID_WIDTH < FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W,
    localparam int EW = SW + 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_word_t      s_data,
    input  logic          out_free,
    output push_t         push,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [EW-1:0] wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [EW-1:0] rd_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_APPLY = 5'b00010,
        ST_READ  = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    in_word_t              in_reg, in_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [1:0]            lock_reg, lock_next;
    logic [READER_W-1:0]   readers_reg, readers_next;
    logic                  pend_valid_reg, pend_valid_next;
    out_word_t             pend_reg, pend_next;

    logic [SW-1:0]         in_id;
    logic                  full;
    logic [AW:0]           tail_sum;
    logic [AW-1:0]         tail;
    logic [AW-1:0]         head_inc;
    logic                  ent_mode;
    logic [SW-1:0]         ent_id;
    logic                  can_grant;
    logic [READER_W-1:0]   readers_dec;

    assign in_id    = in_reg.requester_id[SW-1:0];
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign tail_sum = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign tail     = (tail_sum >= (AW+1)'(QUEUE_DEPTH))
                    ? AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign ent_mode = rd_data[SW];
    assign ent_id   = rd_data[SW-1:0];
    assign can_grant = ent_mode ? (lock_reg == LOCK_FREE)
                                : (lock_reg == LOCK_FREE || lock_reg == LOCK_SHARED);
    assign readers_dec = (readers_reg != '0) ? readers_reg - 1'b1 : '0;

    assign s_ready = (state_reg == ST_IDLE);
    assign wr_addr = tail;
    assign wr_data = {in_reg.mode, in_id};
    assign rd_addr = head_reg;

    always_comb begin
        state_next      = state_reg;
        in_next         = in_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        lock_next       = lock_reg;
        readers_next    = readers_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = '0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (in_reg.kind == KIND_ACQUIRE) begin
                    if (full) begin
                        if (out_free) begin
                            push.valid             = 1'b1;
                            push.word.status       = STATUS_FULL;
                            push.word.granted_id   = FIELD_ID_W'(in_id);
                            push.word.granted_mode = in_reg.mode;
                            push.word.last         = 1'b1;
                            state_next             = ST_IDLE;
                        end
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end else begin
                    if (lock_reg == LOCK_FREE) begin
                        if (out_free) begin
                            push.valid             = 1'b1;
                            push.word.status       = STATUS_UNLOCKED;
                            push.word.granted_id   = '0;
                            push.word.granted_mode = MODE_SHARED;
                            push.word.last         = 1'b1;
                            state_next             = ST_IDLE;
                        end
                    end else if (lock_reg == LOCK_SHARED) begin
                        readers_next = readers_dec;
                        if (readers_dec == '0) begin
                            lock_next = LOCK_FREE;
                        end
                        state_next = ST_READ;
                    end else begin
                        lock_next    = LOCK_FREE;
                        readers_next = '0;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (count_reg == '0) begin
                    state_next = ST_FLUSH;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (can_grant) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            push.valid = 1'b1;
                            push.word  = pend_reg;
                        end
                        pend_valid_next        = 1'b1;
                        pend_next.status       = STATUS_GRANT;
                        pend_next.granted_id   = FIELD_ID_W'(ent_id);
                        pend_next.granted_mode = ent_mode;
                        pend_next.last         = 1'b0;
                        if (ent_mode == MODE_EXCL) begin
                            lock_next = LOCK_EXCL;
                        end else begin
                            lock_next = LOCK_SHARED;
                            if (readers_reg != READER_MAX) begin
                                readers_next = readers_reg + 1'b1;
                            end
                        end
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    push.valid      = 1'b1;
                    push.word       = pend_reg;
                    push.word.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            lock_reg       <= LOCK_FREE;
            readers_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            lock_reg       <= lock_next;
            readers_reg    <= readers_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        pend_reg <= pend_next;
    end

endmodule

/* sv/fifo_fair_reader_writer_lock.sv */
// Top level of the fair reader-writer lock manager.
//
// Input channel (s_valid/s_ready/s_data) takes one event word: an acquire
// (requester id, shared or exclusive) or a release of one held lock.
// Acquires wait in a FIFO kept in a single-port-write RAM. After each event
// the head of the FIFO is granted while it can be: shared requests while the
// lock is not exclusive, an exclusive request only when the lock is free.
// Result channel (m_valid/m_ready/m_data) carries one word per grant; the
// final word of an event has last set. Queue-full rejects and releases while
// unlocked give a single status word; an event that grants nothing gives none.
// Steps with a ready receiver: an event passes through capture, update, one RAM
// read and one evaluate per grant and per blocked head, an empty check when
// the run empties the queue, and a flush; a reject or a release while
// unlocked ends after capture and update. The RAM read-evaluate loop sets
// the per-grant cost. One grant is held back until the next one (or the end
// of the run) decides its last flag.
// Reset (aresetn low, synchronous) empties the queue, frees the lock and
// clears the reader count. A stalled receiver holds the output register;
// the sequencer waits at its next push until the register frees.
module fifo_fair_reader_writer_lock
    import ffrw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int SW = (ID_WIDTH < FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;
    localparam int EW = SW + 1;

    push_t         push;
    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    ffrw_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .push     (push),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    ffrw_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_wait_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ffrw_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* sv/ffrw_checker.sv */
// Port-level checker for the lock manager, bound to the top level.
module ffrw_checker
    import ffrw_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == STATUS_GRANT || m_data.status == STATUS_FULL
                 || m_data.status == STATUS_UNLOCKED)
        else $error("undefined status code");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_GRANT |-> m_data.last)
        else $error("status word without last");

    a_unlocked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_UNLOCKED
        |-> m_data.granted_id == '0 && m_data.granted_mode == MODE_SHARED)
        else $error("release-while-unlocked word carries data");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind fifo_fair_reader_writer_lock ffrw_checker u_checker (.*);
